// ===== src/oicg_pkg.sv =====
// Shared types, codes and constants of the obstacle inflation cost grid.
package oicg_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int DIST_W   = 6;
	localparam int COST_W   = 7;
	localparam int CELL_W   = 8;
	localparam int CFG_W    = 9;
	localparam int RADIUS_W = 5;
	localparam int MODE_W   = 2;
	localparam int REG_W    = 2;

	localparam logic [DIST_W-1:0] FAR_DIST   = 6'd63;
	localparam int                RING_COUNT = 3;

	localparam logic [COST_W-1:0] COST_CORE  = 7'd100;
	localparam logic [COST_W-1:0] COST_RING1 = 7'd90;
	localparam logic [COST_W-1:0] COST_RING2 = 7'd70;
	localparam logic [COST_W-1:0] COST_RING3 = 7'd50;
	localparam logic [COST_W-1:0] COST_FREE  = 7'd0;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	localparam logic [REG_W-1:0] REG_INFLATE = 2'd0;
	localparam logic [REG_W-1:0] REG_WIDTH   = 2'd1;
	localparam logic [REG_W-1:0] REG_HEIGHT  = 2'd2;

	// Hand-off of one looked-up query from the sequencer to the output stage.
	typedef struct packed {
		logic              load;
		logic              in_map;
		logic [DIST_W-1:0] near_d;
	} qry_t;

endpackage

// ===== src/oicg_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module oicg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/oicg_seq.sv =====
// Sequencer: clearing sweep, window walk with read-modify-write, and query lookup.
module oicg_seq import oicg_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [CELL_W-1:0]   cell_x,
	input  logic [CELL_W-1:0]   cell_y,
	input  logic [RADIUS_W-1:0] inflate_cells,
	input  logic [CFG_W-1:0]    map_width,
	input  logic [CFG_W-1:0]    map_height,
	input  logic                out_free,
	output qry_t                qry,
	output logic                ram_we,
	output logic [ADDR_W-1:0]   ram_waddr,
	output logic [DIST_W-1:0]   ram_wdata,
	output logic                ram_re,
	output logic [ADDR_W-1:0]   ram_raddr,
	input  logic [DIST_W-1:0]   ram_rdata
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int DIM_W = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
	localparam int CMP_W = (DIM_W > 9 ? DIM_W : 9) + 1;
	localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
	localparam logic [CMP_W-1:0] MAX_H_C = CMP_W'(MAX_HEIGHT);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_QRY   = 3'd4;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [CELL_W-1:0] cx_q;
	logic [CELL_W-1:0] cy_q;
	logic [6:0]        dx_q;
	logic [6:0]        dy_q;
	logic              qin_map_q;

	logic              wb_valid_s1;
	logic [ADDR_W-1:0] wb_addr_s1;
	logic [DIST_W-1:0] wb_dist_s1;

	logic [6:0]        rad;
	logic [6:0]        neg_rad;
	logic [9:0]        cur_x;
	logic [9:0]        cur_y;
	logic [CMP_W-1:0]  w_eff;
	logic [CMP_W-1:0]  h_eff;
	logic              in_map;
	logic [ADDR_W-1:0] cur_addr;
	logic [6:0]        ax;
	logic [6:0]        ay;
	logic [DIST_W-1:0] cur_dist;
	logic              accept;
	logic              walk_end;
	logic              lower;

	assign rad     = 7'(inflate_cells) + 7'(RING_COUNT);
	assign neg_rad = 7'd0 - rad;

	assign w_eff = (CMP_W'(map_width) < MAX_W_C) ? CMP_W'(map_width) : MAX_W_C;
	assign h_eff = (CMP_W'(map_height) < MAX_H_C) ? CMP_W'(map_height) : MAX_H_C;

	// In the idle state the coordinates come from the input; during the walk
	// they are the center plus the signed window offsets.
	always_comb begin
		if (state_q == S_WALK) begin
			cur_x = {2'b00, cx_q} + {{3{dx_q[6]}}, dx_q};
			cur_y = {2'b00, cy_q} + {{3{dy_q[6]}}, dy_q};
		end else begin
			cur_x = {2'b00, cell_x};
			cur_y = {2'b00, cell_y};
		end
	end

	assign in_map = !cur_x[9] && (CMP_W'(cur_x[8:0]) < w_eff) &&
		!cur_y[9] && (CMP_W'(cur_y[8:0]) < h_eff);
	assign cur_addr = ADDR_W'(cur_y[8:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cur_x[8:0]);

	assign ax       = dx_q[6] ? (7'd0 - dx_q) : dx_q;
	assign ay       = dy_q[6] ? (7'd0 - dy_q) : dy_q;
	assign cur_dist = (ax > ay) ? DIST_W'(ax) : DIST_W'(ay);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign walk_end = (dx_q == rad) && (dy_q == rad);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cur_addr;
		if (state_q == S_WALK) begin
			ram_re = in_map;
		end else if (accept && (mode == MODE_QUERY)) begin
			ram_re = in_map;
		end
	end

	assign lower     = wb_valid_s1 && (wb_dist_s1 < ram_rdata);
	assign ram_we    = (state_q == S_CLR) || lower;
	assign ram_waddr = (state_q == S_CLR) ? sweep_q : wb_addr_s1;
	assign ram_wdata = (state_q == S_CLR) ? FAR_DIST : wb_dist_s1;

	assign qry.load   = (state_q == S_QRY) && out_free;
	assign qry.in_map = qin_map_q;
	assign qry.near_d = ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			sweep_q     <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			wb_valid_s1 <= 1'b0;
		end else begin
			wb_valid_s1 <= (state_q == S_WALK) && in_map;
			case (state_q)
				S_CLR: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_INSERT: begin
								if (in_map) begin
									state_q <= S_WALK;
									dx_q    <= neg_rad;
									dy_q    <= neg_rad;
								end
							end
							MODE_QUERY: begin
								state_q <= S_QRY;
							end
							MODE_CLEAR: begin
								state_q <= S_CLR;
								sweep_q <= '0;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (walk_end) begin
						state_q <= S_DRAIN;
					end else if (dx_q == rad) begin
						dx_q <= neg_rad;
						dy_q <= dy_q + 7'd1;
					end else begin
						dx_q <= dx_q + 7'd1;
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				S_QRY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wb_addr_s1 <= cur_addr;
		wb_dist_s1 <= cur_dist;
		if (accept) begin
			cx_q      <= cell_x;
			cy_q      <= cell_y;
			qin_map_q <= in_map;
		end
	end

endmodule

// ===== src/oicg_out.sv =====
// Output stage: maps a stored distance to a cost and holds the result register.
module oicg_out import oicg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [RADIUS_W-1:0] inflate_cells,
	input  qry_t                qry,
	output logic                out_free,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [COST_W-1:0]   cost_value
);

	logic              out_valid_q;
	logic [COST_W-1:0] cost_q;
	logic [COST_W-1:0] cost;
	logic [6:0]        d7;
	logic [6:0]        r7;

	assign d7 = 7'(qry.near_d);
	assign r7 = 7'(inflate_cells);

	always_comb begin
		if (!qry.in_map) begin
			cost = COST_FREE;
		end else if (d7 <= r7) begin
			cost = COST_CORE;
		end else if (d7 == r7 + 7'd1) begin
			cost = COST_RING1;
		end else if (d7 == r7 + 7'd2) begin
			cost = COST_RING2;
		end else if (d7 == r7 + 7'd3) begin
			cost = COST_RING3;
		end else begin
			cost = COST_FREE;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (qry.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (qry.load) begin
			cost_q <= cost;
		end
	end

	assign out_valid  = out_valid_q;
	assign cost_value = cost_q;

endmodule

// ===== src/obstacle_inflation_cost_grid_top.sv =====
// Top level of the obstacle inflation cost grid: configuration, RAM and control.
//
// The block keeps one 6-bit saturated Chebyshev distance per grid cell in a
// single RAM of MAX_WIDTH*MAX_HEIGHT entries (cell y*MAX_WIDTH+x), with a
// registered read port. An insert transaction walks the square window of
// radius inflate_cells+3 around the cell (inflate_cells resets to 10), one
// window cell per clock, reading each in-map entry and writing it back in the
// following cycle when the new distance is smaller; an in-map insert keeps the
// input busy through the walk and a final drain state for the last write-back,
// and an insert outside the map is dropped with the block left idle. A query
// does the RAM read, then the cost lookup into the output register, and waits
// while that register holds a stalled result; the register lets the input
// move on while the result waits to be taken. A clear sweeps every RAM entry
// once, and the same sweep runs right after reset, with in_stall high.
// Configuration writes are taken in any cycle but must only be issued while
// the block is idle.
module obstacle_inflation_cost_grid_top import oicg_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [REG_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [CELL_W-1:0] cell_x,
	input  logic [CELL_W-1:0] cell_y,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [COST_W-1:0] cost_value
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [RADIUS_W-1:0] inflate_q;
	logic [CFG_W-1:0]    width_q;
	logic [CFG_W-1:0]    height_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [DIST_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [DIST_W-1:0]   ram_rdata;
	qry_t                qry;
	logic                out_free;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflate_q <= 5'd10;
			width_q   <= 9'd256;
			height_q  <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INFLATE: inflate_q <= cfg_data[RADIUS_W-1:0];
				REG_WIDTH:   width_q   <= cfg_data;
				REG_HEIGHT:  height_q  <= cfg_data;
				default: begin
					inflate_q <= inflate_q;
				end
			endcase
		end
	end

	oicg_ram #(
		.WIDTH(DIST_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	oicg_seq #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.inflate_cells(inflate_q),
		.map_width    (width_q),
		.map_height   (height_q),
		.out_free     (out_free),
		.qry          (qry),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	oicg_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.inflate_cells(inflate_q),
		.qry          (qry),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cost_value   (cost_value)
	);

	// A read and a write-back never touch the same entry in one cycle.
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_re && ram_we && (ram_raddr == ram_waddr)))
		else $error("read and write of the same RAM entry in one cycle");

	// No write-back is still pending when a new transaction is taken.
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !ram_we)
		else $error("RAM write in the cycle a transaction is accepted");

	// A new result only follows a cycle in which the lookup held the input.
	a_result_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a preceding lookup cycle");

endmodule
